### rtl/intron_support_table_defines.svh
// Assertion macros used by the RTL that carries concurrent checks.
`ifndef INTRON_SUPPORT_TABLE_DEFINES_SVH
`define INTRON_SUPPORT_TABLE_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define IST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define IST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ist_pkg.sv
`default_nettype none
package ist_pkg;

  // Default sizes of the table.
  localparam int unsigned DEF_MAX_POSITIONS = 1024;
  localparam int unsigned DEF_MAX_RECORDS   = 8;

  // Operation codes of an input item.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Status codes of a result item.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNSORTED  = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_UNMATCHED = 3'd4;
  localparam logic [2:0] ST_BAD_SPAN  = 3'd5;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_LOAD_CLR,
    S_ADD_START,
    S_ADD_RD,
    S_ADD_CMP,
    S_ADD_DEC,
    S_Q_START,
    S_Q_HDR,
    S_Q_RD,
    S_Q_CMP,
    S_DONE
  } seq_state_t;

endpackage
`default_nettype wire

### rtl/ist_in_if.sv
`default_nettype none
interface ist_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [9:0]  index;
  logic [30:0] position;
  logic        new_batch;
  logic [30:0] intron_start;
  logic [30:0] intron_end;
  logic signed [31:0] intron_quality;
  logic [9:0]  from_index;
  logic [9:0]  to_index;

  modport source (output valid, operation, index, position, new_batch, intron_start,
                  intron_end, intron_quality, from_index, to_index, input ready);
  modport sink (input valid, operation, index, position, new_batch, intron_start,
                intron_end, intron_quality, from_index, to_index, output ready);
endinterface

interface ist_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  coverage;
  logic signed [31:0] best_quality;
  logic [2:0]  status;

  modport source (output valid, coverage, best_quality, status, input ready);
  modport sink (input valid, coverage, best_quality, status, output ready);
endinterface
`default_nettype wire

### rtl/intron_support_table.sv
// Intron support table. Items are taken one at a time; in_ch.ready is high only while the
// sequencer is idle. A load writes the position and empties its list; a load at index 0
// also empties every other list with one write per cycle. The unused operation code 3
// goes straight to the result. An add steps the merge cursor over the positions below
// its end and then compares, and a query compares each record of to_index in turn. Each
// step is a registered read of the position or record memory followed by a compare.
// A finished result sits in the output register and the next item is taken while it
// waits. No clearing pass runs after reset: a list is emptied whenever its position is
// loaded, and all lists are emptied by the pass that follows a load at index 0.
`default_nettype none
`include "intron_support_table_defines.svh"
module intron_support_table
  import ist_pkg::*;
#(
  parameter int unsigned MAX_POSITIONS            = DEF_MAX_POSITIONS,
  parameter int unsigned MAX_RECORDS_PER_POSITION = DEF_MAX_RECORDS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ist_in_if.sink    in_ch,
  ist_out_if.source out_ch
);

  localparam int unsigned AW   = $clog2(MAX_POSITIONS);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned RCW  = $clog2(MAX_RECORDS_PER_POSITION + 1);
  localparam int unsigned SAW  = $clog2(MAX_POSITIONS * MAX_RECORDS_PER_POSITION);
  localparam int unsigned NREC = MAX_POSITIONS * MAX_RECORDS_PER_POSITION;

  // Storage.
  logic [30:0]        pos_mem   [MAX_POSITIONS];
  logic [RCW-1:0]     cnt_mem   [MAX_POSITIONS];
  logic [30:0]        rstart_mem[NREC];
  logic signed [31:0] rqual_mem [NREC];

  // Sequencer and item registers.
  seq_state_t state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [16:0] idx_r, idx_nxt;
  logic [30:0] pos_r, pos_nxt;
  logic        fresh_r, fresh_nxt;
  logic [30:0] start_r, start_nxt;
  logic [30:0] end_r, end_nxt;
  logic signed [31:0] qual_r, qual_nxt;
  logic [16:0] from_r, from_nxt;
  logic [16:0] to_r, to_nxt;
  logic [CW-1:0]  cursor_r, cursor_nxt;
  logic [CW-1:0]  pcount_r, pcount_nxt;
  logic [30:0]    prev_end_r, prev_end_nxt;
  logic           match_r, match_nxt;
  logic [30:0]    want_r, want_nxt;
  logic [RCW-1:0] n_r, n_nxt;
  logic [RCW-1:0] k_r, k_nxt;
  logic [RCW-1:0] cov_r, cov_nxt;
  logic signed [31:0] best_r, best_nxt;
  logic [2:0]     status_r, status_nxt;

  // Output register.
  logic           out_valid_r, out_valid_nxt;
  logic [3:0]     out_cov_r, out_cov_nxt;
  logic signed [31:0] out_best_r, out_best_nxt;
  logic [2:0]     out_status_r, out_status_nxt;

  // Memory ports.
  logic                pos_we, cnt_we, rec_we;
  logic [AW-1:0]       pos_waddr, pos_raddr, cnt_waddr, cnt_raddr;
  logic [30:0]         pos_wdata;
  logic [RCW-1:0]      cnt_wdata;
  logic [SAW-1:0]      rec_waddr, rec_raddr;
  logic [30:0]         pos_rd_r, rstart_rd_r;
  logic [RCW-1:0]      cnt_rd_r;
  logic signed [31:0]  rqual_rd_r;

  logic in_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.coverage     = out_cov_r;
  assign out_ch.best_quality = out_best_r;
  assign out_ch.status       = out_status_r;

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (rec_we) begin
      rstart_mem[rec_waddr] <= start_r;
      rqual_mem[rec_waddr]  <= qual_r;
    end
    pos_rd_r    <= pos_mem[pos_raddr];
    cnt_rd_r    <= cnt_mem[cnt_raddr];
    rstart_rd_r <= rstart_mem[rec_raddr];
    rqual_rd_r  <= rqual_mem[rec_raddr];
  end

  // State and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      pcount_r    <= '0;
      prev_end_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      pcount_r    <= pcount_nxt;
      prev_end_r  <= prev_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt;  idx_r <= idx_nxt;  pos_r <= pos_nxt;  fresh_r <= fresh_nxt;
    start_r <= start_nxt;  end_r <= end_nxt;  qual_r <= qual_nxt;
    from_r <= from_nxt;  to_r <= to_nxt;  match_r <= match_nxt;  want_r <= want_nxt;
    n_r <= n_nxt;  k_r <= k_nxt;  cov_r <= cov_nxt;  best_r <= best_nxt;
    status_r <= status_nxt;
    out_cov_r <= out_cov_nxt;  out_best_r <= out_best_nxt;  out_status_r <= out_status_nxt;
  end

  // Sequencer: next state, shared compare and memory control.
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;  idx_nxt = idx_r;  pos_nxt = pos_r;  fresh_nxt = fresh_r;
    start_nxt = start_r;  end_nxt = end_r;  qual_nxt = qual_r;
    from_nxt = from_r;  to_nxt = to_r;
    cursor_nxt = cursor_r;  pcount_nxt = pcount_r;  prev_end_nxt = prev_end_r;
    match_nxt = match_r;  want_nxt = want_r;  n_nxt = n_r;  k_nxt = k_r;
    cov_nxt = cov_r;  best_nxt = best_r;  status_nxt = status_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cov_nxt = out_cov_r;  out_best_nxt = out_best_r;  out_status_nxt = out_status_r;
    pos_we = 1'b0;  cnt_we = 1'b0;  rec_we = 1'b0;
    pos_waddr = idx_r[AW-1:0];  pos_wdata = pos_r;  pos_raddr = cursor_r[AW-1:0];
    cnt_waddr = idx_r[AW-1:0];  cnt_wdata = '0;     cnt_raddr = cursor_r[AW-1:0];
    rec_waddr = SAW'(cursor_r[AW-1:0]) * SAW'(MAX_RECORDS_PER_POSITION) + SAW'(cnt_rd_r);
    rec_raddr = SAW'(to_r[AW-1:0]) * SAW'(MAX_RECORDS_PER_POSITION) + SAW'(k_r);

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt = in_ch.operation;
          idx_nxt = 17'(in_ch.index);
          pos_nxt = in_ch.position;
          fresh_nxt = in_ch.new_batch;
          start_nxt = in_ch.intron_start;
          end_nxt = in_ch.intron_end;
          qual_nxt = in_ch.intron_quality;
          from_nxt = 17'(in_ch.from_index);
          to_nxt = 17'(in_ch.to_index);
          cov_nxt = '0;
          best_nxt = '0;
          status_nxt = ST_OK;
          case (in_ch.operation)
            OP_LOAD:  state_nxt = S_LOAD;
            OP_ADD:   state_nxt = S_ADD_START;
            OP_QUERY: state_nxt = S_Q_START;
            default:  state_nxt = S_DONE;
          endcase
        end
      end

      // Write the position and empty its list; index 0 restarts the table.
      S_LOAD: begin
        state_nxt = S_DONE;
        if (idx_r >= 17'(MAX_POSITIONS)) begin
          status_nxt = ST_RANGE;
        end else begin
          pos_we = 1'b1;
          cnt_we = 1'b1;
          pcount_nxt = CW'(idx_r) + CW'(1);
          if (idx_r == '0) begin
            cursor_nxt = '0;
            prev_end_nxt = '0;
            idx_nxt = 17'd1;
            state_nxt = S_LOAD_CLR;
          end else if (cursor_r > CW'(idx_r) + CW'(1)) begin
            cursor_nxt = CW'(idx_r) + CW'(1);
          end
        end
      end

      // Empty the remaining lists one entry per cycle after a load at index 0.
      S_LOAD_CLR: begin
        cnt_we = 1'b1;
        idx_nxt = idx_r + 17'd1;
        if (idx_r == 17'(MAX_POSITIONS - 1)) state_nxt = S_DONE;
      end

      // Sort check on the end position.
      S_ADD_START: begin
        if (fresh_r) begin
          cursor_nxt = '0;
          prev_end_nxt = '0;
        end
        if (!fresh_r && end_r < prev_end_r) begin
          status_nxt = ST_UNSORTED;
          state_nxt = S_DONE;
        end else begin
          prev_end_nxt = end_r;
          state_nxt = S_ADD_RD;
        end
      end

      // Fetch the position under the cursor, unless the table is exhausted.
      S_ADD_RD: begin
        if (cursor_r >= pcount_r) begin
          match_nxt = 1'b0;
          state_nxt = S_ADD_DEC;
        end else begin
          state_nxt = S_ADD_CMP;
        end
      end

      // Step the cursor while the position lies below the end.
      S_ADD_CMP: begin
        if (pos_rd_r < end_r) begin
          cursor_nxt = cursor_r + CW'(1);
          state_nxt = S_ADD_RD;
        end else begin
          match_nxt = (pos_rd_r == end_r);
          state_nxt = S_ADD_DEC;
        end
      end

      // Decide and append the record.
      S_ADD_DEC: begin
        if (start_r >= end_r) begin
          status_nxt = ST_BAD_SPAN;
        end else if (!match_r) begin
          status_nxt = ST_UNMATCHED;
        end else if (cnt_rd_r >= RCW'(MAX_RECORDS_PER_POSITION)) begin
          status_nxt = ST_FULL;
        end else begin
          rec_we = 1'b1;
          cnt_we = 1'b1;
          cnt_waddr = cursor_r[AW-1:0];
          cnt_wdata = cnt_rd_r + RCW'(1);
        end
        state_nxt = S_DONE;
      end

      // Range check, then fetch the sought start and the list length.
      S_Q_START: begin
        if (from_r >= 17'(pcount_r) || to_r >= 17'(pcount_r)) begin
          status_nxt = ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          pos_raddr = from_r[AW-1:0];
          cnt_raddr = to_r[AW-1:0];
          state_nxt = S_Q_HDR;
        end
      end

      S_Q_HDR: begin
        want_nxt = pos_rd_r;
        n_nxt = (cnt_rd_r > RCW'(MAX_RECORDS_PER_POSITION)) ?
                RCW'(MAX_RECORDS_PER_POSITION) : cnt_rd_r;
        k_nxt = '0;
        state_nxt = S_Q_RD;
      end

      // Each record is read, then compared.
      S_Q_RD: begin
        state_nxt = (k_r >= n_r) ? S_DONE : S_Q_CMP;
      end

      S_Q_CMP: begin
        if (rstart_rd_r == want_r) begin
          cov_nxt = cov_r + RCW'(1);
          if (rqual_rd_r > best_r) best_nxt = rqual_rd_r;
        end
        k_nxt = k_r + RCW'(1);
        state_nxt = S_Q_RD;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cov_nxt = 4'(cov_r);
          out_best_nxt = best_r;
          out_status_nxt = status_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Checks.
  `IST_ASSERT_NEXT(a_busy_after_accept, in_fire, state_r != S_IDLE,
                   "sequencer stayed idle after taking an item")
  `IST_ASSERT_SAME(a_cursor_bounded, 1'b1, cursor_r <= pcount_r,
                   "merge cursor ran past the loaded positions")
  `IST_ASSERT_SAME(a_cov_only_ok, out_valid_r && out_cov_r != '0, out_status_r == ST_OK,
                   "nonzero coverage reported with an error status")

endmodule
`default_nettype wire
